// ===== rtl/triangle_scan_convert_depth_defines.svh =====
// Assertion macros used by the top-level RTL file of the triangle depth rasteriser.
`ifndef TRIANGLE_SCAN_CONVERT_DEPTH_DEFINES_SVH
`define TRIANGLE_SCAN_CONVERT_DEPTH_DEFINES_SVH

// Generic clocked assertion with an active-low reset that disables it.
`define TSCD_ASSERT(name, clk, rstn, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Assertion on the block clock and reset.
`define TSCD_ASSERT_CLK(name, prop, msg) \
    `TSCD_ASSERT(name, aclk, aresetn, prop, msg)

`endif

// ===== rtl/tscd_pkg.sv =====
// Package with the transfer types and operation codes of the triangle depth rasteriser.
`default_nettype none
package tscd_pkg;

    localparam int COORD_W = 6;
    localparam int VZ_W    = 16;
    localparam int PROBE_W = 5;
    localparam int OP_W    = 2;
    localparam int PIX_W   = 16;

    localparam logic [OP_W-1:0] OP_DRAW  = 2'd0;
    localparam logic [OP_W-1:0] OP_READ  = 2'd1;
    localparam logic [OP_W-1:0] OP_CLEAR = 2'd2;
    localparam logic [OP_W-1:0] OP_NOP   = 2'd3;

    typedef struct packed {
        logic [OP_W-1:0]    op;
        logic [COORD_W-1:0] vertex0_x;
        logic [COORD_W-1:0] vertex0_y;
        logic [VZ_W-1:0]    vertex0_z;
        logic [COORD_W-1:0] vertex1_x;
        logic [COORD_W-1:0] vertex1_y;
        logic [VZ_W-1:0]    vertex1_z;
        logic [COORD_W-1:0] vertex2_x;
        logic [COORD_W-1:0] vertex2_y;
        logic [VZ_W-1:0]    vertex2_z;
        logic [PROBE_W-1:0] probe_col;
        logic [PROBE_W-1:0] probe_row;
    } tscd_in_t;

    typedef struct packed {
        logic [PIX_W-1:0] pixel_value;
        logic [OP_W-1:0]  op_done;
    } tscd_out_t;

endpackage
`default_nettype wire

// ===== rtl/tscd_ram.sv =====
// Generic single-port synchronous RAM with a registered read.
`default_nettype none
module tscd_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  wire logic                     clk,
    input  wire logic                     en,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] addr,
    input  wire logic [WIDTH-1:0]         wdata,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk) begin
        if (en) begin
            if (we) begin
                mem[addr] <= wdata;
            end else begin
                rdata <= mem[addr];
            end
        end
    end

endmodule
`default_nettype wire

// ===== rtl/triangle_scan_convert_depth.sv =====
// Top level of the scanline triangle rasteriser with a depth grid in RAM.
//
//  channel | direction | handshake        | payload
//  s_      | in        | s_valid/s_ready  | s_data  (tscd_in_t)
//  m_      | out       | m_valid/m_ready  | m_data  (tscd_out_t)
//
// After reset a clearing pass writes zero to all GRID_SIDE*GRID_SIDE cells, one a
// cycle, with s_ready low; op 2 repeats that pass before its result.
// A draw is paced by the serial divider, which yields one quotient bit per cycle.
// A new transfer is taken while a finished result still waits on m_ready.
`default_nettype none
module triangle_scan_convert_depth #(
    parameter int GRID_SIDE  = 32,
    parameter int DEPTH_BITS = 16
) (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                s_valid,
    output logic                     s_ready,
    input  wire tscd_pkg::tscd_in_t  s_data,
    output logic                     m_valid,
    input  wire logic                m_ready,
    output tscd_pkg::tscd_out_t      m_data
);

    import tscd_pkg::*;
`include "triangle_scan_convert_depth_defines.svh"

    localparam int CELLS  = GRID_SIDE * GRID_SIDE;
    localparam int ADDR_W = $clog2(CELLS);
    localparam int DIV_W  = 38;
    localparam int CNT_W  = $clog2(DIV_W + 1);
    localparam logic [32:0] MAXZ = (33'd1 << DEPTH_BITS) - 33'd1;

    typedef enum logic [3:0] {
        ST_CLR, ST_IDLE, ST_RD, ST_ROW, ST_EDGE, ST_EDGE_W, ST_SPAN,
        ST_QA_W, ST_PIX_T, ST_PIX_DW, ST_PIX_W, ST_FIN
    } state_t;

    state_t state_reg;

    logic [ADDR_W-1:0]     clr_addr_reg;
    logic                  clr_op_reg;
    logic [OP_W-1:0]       op_reg;
    logic [PIX_W-1:0]      res_reg;
    logic                  m_valid_reg;
    tscd_out_t             m_data_reg;

    logic [COORD_W-1:0]    xl_reg, yl_reg, xm_reg, ym_reg, xh_reg, yh_reg;
    logic [VZ_W-1:0]       zl_reg, zm_reg, zh_reg;
    logic [COORD_W-1:0]    row_reg;
    logic                  upper_reg;
    logic [1:0]            k_reg;
    logic                  eneg_reg;
    logic [VZ_W-1:0]       ebase_reg;
    logic signed [25:0]    xa_reg, za_reg, xb_reg, zb_reg;

    logic [14:0]           xr_reg, hi_reg;
    logic signed [25:0]    zr_reg;
    logic                  dneg_reg;
    logic [23:0]           dmag_reg;
    logic [13:0]           dab_reg;
    logic [6:0]            i_reg;
    logic                  have_reg;
    logic [13:0]           tprev_reg;
    logic [37:0]           q_reg;
    logic [13:0]           rem_reg;
    logic [31:0]           qa_reg;
    logic [13:0]           ra_reg;

    logic [DIV_W-1:0]      div_num_reg;
    logic [13:0]           div_rem_reg;
    logic [13:0]           div_den_reg;
    logic [CNT_W-1:0]      div_cnt_reg;
    logic                  div_start;
    logic [DIV_W-1:0]      div_dividend;
    logic [13:0]           div_divisor;
    logic [14:0]           div_trial;
    logic                  div_done;

    logic                  ram_en, ram_we;
    logic [ADDR_W-1:0]     ram_addr;
    logic [DEPTH_BITS-1:0] ram_wdata, ram_rdata;

    logic                  accept;
    logic                  probe_in;
    logic [COORD_W-1:0]    sx [3];
    logic [COORD_W-1:0]    sy [3];
    logic [VZ_W-1:0]       sz [3];

    logic [VZ_W-1:0]       e_v0, e_v1;
    logic [COORD_W-1:0]    e_num, e_den;
    logic signed [16:0]    e_diff;
    logic [15:0]           e_mag;
    logic signed [25:0]    e_val;
    logic [COORD_W-1:0]    row_step;
    logic                  ref_a;
    logic signed [26:0]    sp_d;
    logic signed [16:0]    sp_x;
    logic signed [16:0]    t_diff;
    logic [13:0]           t_cur;
    logic                  pix_go;
    logic [14:0]           inc_sum;
    logic signed [39:0]    z_full;
    logic [32:0]           z_shift;
    logic [DEPTH_BITS-1:0] pz;
    logic [31:0]           rd_ext;

    assign accept   = s_valid && s_ready;
    assign s_ready  = (state_reg == ST_IDLE);
    assign m_valid  = m_valid_reg;
    assign m_data   = m_data_reg;
    assign probe_in = (int'(s_data.probe_col) < GRID_SIDE) &&
                      (int'(s_data.probe_row) < GRID_SIDE);
    assign rd_ext   = 32'(ram_rdata);

    // Vertex sort by row: compare-and-swap on (0,1), (1,2), (0,1).
    always_comb begin
        logic [COORD_W-1:0] tx, ty;
        logic [VZ_W-1:0]    tz;
        tx = '0; ty = '0; tz = '0;
        sx[0] = s_data.vertex0_x; sy[0] = s_data.vertex0_y; sz[0] = s_data.vertex0_z;
        sx[1] = s_data.vertex1_x; sy[1] = s_data.vertex1_y; sz[1] = s_data.vertex1_z;
        sx[2] = s_data.vertex2_x; sy[2] = s_data.vertex2_y; sz[2] = s_data.vertex2_z;
        if (sy[0] > sy[1]) begin
            tx = sx[0]; ty = sy[0]; tz = sz[0];
            sx[0] = sx[1]; sy[0] = sy[1]; sz[0] = sz[1];
            sx[1] = tx; sy[1] = ty; sz[1] = tz;
        end
        if (sy[1] > sy[2]) begin
            tx = sx[1]; ty = sy[1]; tz = sz[1];
            sx[1] = sx[2]; sy[1] = sy[2]; sz[1] = sz[2];
            sx[2] = tx; sy[2] = ty; sz[2] = tz;
        end
        if (sy[0] > sy[1]) begin
            tx = sx[0]; ty = sy[0]; tz = sz[0];
            sx[0] = sx[1]; sy[0] = sy[1]; sz[0] = sz[1];
            sx[1] = tx; sy[1] = ty; sz[1] = tz;
        end
    end

    // Edge operands: side A runs H to L, side B runs H to M above yM, L to M below.
    always_comb begin
        if (!k_reg[1]) begin
            e_v0  = k_reg[0] ? zh_reg : VZ_W'(xh_reg);
            e_v1  = k_reg[0] ? zl_reg : VZ_W'(xl_reg);
            e_num = yh_reg - row_reg;
            e_den = yh_reg - yl_reg;
        end else if (upper_reg) begin
            e_v0  = k_reg[0] ? zh_reg : VZ_W'(xh_reg);
            e_v1  = k_reg[0] ? zm_reg : VZ_W'(xm_reg);
            e_num = yh_reg - row_reg;
            e_den = yh_reg - ym_reg;
        end else begin
            e_v0  = k_reg[0] ? zl_reg : VZ_W'(xl_reg);
            e_v1  = k_reg[0] ? zm_reg : VZ_W'(xm_reg);
            e_num = row_reg - yl_reg;
            e_den = ym_reg - yl_reg;
        end
        e_diff = $signed({1'b0, e_v1}) - $signed({1'b0, e_v0});
        e_mag  = e_diff[16] ? 16'(-e_diff) : e_diff[15:0];
        e_val  = eneg_reg ? $signed({2'b0, ebase_reg, 8'b0}) - $signed(26'(div_num_reg))
                          : $signed({2'b0, ebase_reg, 8'b0}) + $signed(26'(div_num_reg));
    end

    always_comb begin
        row_step = upper_reg ? row_reg + COORD_W'(1) : row_reg - COORD_W'(1);
        ref_a    = upper_reg || (xa_reg <= xb_reg);
        sp_d     = ref_a ? 27'(zb_reg) - 27'(za_reg) : 27'(za_reg) - 27'(zb_reg);
        sp_x     = $signed(17'(xb_reg[14:0])) - $signed(17'(xa_reg[14:0]));
        t_diff   = $signed({2'b0, i_reg, 8'b0}) - $signed({2'b0, xr_reg});
        t_cur    = t_diff[16] ? 14'(-t_diff) : t_diff[13:0];
        pix_go   = ({i_reg, 8'b0} < hi_reg) && (int'(i_reg) < GRID_SIDE);
        inc_sum  = {1'b0, rem_reg} + {1'b0, ra_reg};
        z_full   = dneg_reg ? 40'(zr_reg) - $signed({2'b0, q_reg})
                            : 40'(zr_reg) + $signed({2'b0, q_reg});
        z_shift  = 33'(z_full[39:8]);
        if (z_full[39]) begin
            pz = '0;
        end else if (z_shift > MAXZ) begin
            pz = DEPTH_BITS'(MAXZ);
        end else begin
            pz = DEPTH_BITS'(z_shift);
        end
    end

    always_comb begin
        div_start    = 1'b0;
        div_dividend = '0;
        div_divisor  = dab_reg;
        case (state_reg)
            ST_EDGE: begin
                div_start    = 1'b1;
                div_dividend = DIV_W'({e_mag * 22'(e_num), 8'b0});
                div_divisor  = 14'(e_den);
            end
            ST_SPAN: begin
                div_start    = (sp_x != 17'sd0);
                div_dividend = DIV_W'({(sp_d[26] ? 24'(-sp_d) : sp_d[23:0]), 8'b0});
                div_divisor  = sp_x[16] ? 14'(-sp_x) : sp_x[13:0];
            end
            ST_PIX_T: begin
                div_start    = pix_go && (dab_reg != '0) &&
                               !(have_reg && ({1'b0, t_cur} == {1'b0, tprev_reg} + 15'd256)) &&
                               !(have_reg && ({1'b0, t_cur} + 15'd256 == {1'b0, tprev_reg}));
                div_dividend = DIV_W'(dmag_reg * 38'(t_cur));
            end
            default: begin
                div_start = 1'b0;
            end
        endcase
    end

    assign div_trial = {div_rem_reg, div_num_reg[DIV_W-1]};
    assign div_done  = (div_cnt_reg == '0);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            div_cnt_reg <= '0;
        end else if (div_start) begin
            div_num_reg <= div_dividend;
            div_den_reg <= div_divisor;
            div_rem_reg <= '0;
            div_cnt_reg <= CNT_W'(DIV_W);
        end else if (!div_done) begin
            if (div_trial >= {1'b0, div_den_reg}) begin
                div_rem_reg <= 14'(div_trial - {1'b0, div_den_reg});
                div_num_reg <= {div_num_reg[DIV_W-2:0], 1'b1};
            end else begin
                div_rem_reg <= div_trial[13:0];
                div_num_reg <= {div_num_reg[DIV_W-2:0], 1'b0};
            end
            div_cnt_reg <= div_cnt_reg - CNT_W'(1);
        end
    end

    always_comb begin
        ram_en    = 1'b0;
        ram_we    = 1'b0;
        ram_addr  = '0;
        ram_wdata = pz;
        case (state_reg)
            ST_CLR: begin
                ram_en    = 1'b1;
                ram_we    = 1'b1;
                ram_addr  = clr_addr_reg;
                ram_wdata = '0;
            end
            ST_IDLE: begin
                ram_en   = accept && (s_data.op == OP_READ) && probe_in;
                ram_addr = ADDR_W'(int'(s_data.probe_row) * GRID_SIDE + int'(s_data.probe_col));
            end
            ST_PIX_W: begin
                ram_en   = 1'b1;
                ram_we   = 1'b1;
                ram_addr = ADDR_W'(int'(row_reg) * GRID_SIDE + int'(i_reg));
            end
            default: begin
                ram_en = 1'b0;
            end
        endcase
    end

    tscd_ram #(
        .WIDTH(DEPTH_BITS),
        .DEPTH(CELLS)
    ) u_grid (
        .clk  (aclk),
        .en   (ram_en),
        .we   (ram_we),
        .addr (ram_addr),
        .wdata(ram_wdata),
        .rdata(ram_rdata)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_CLR;
            clr_addr_reg <= '0;
            clr_op_reg   <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            if (m_valid_reg && m_ready && (state_reg != ST_FIN)) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_CLR: begin
                    clr_addr_reg <= clr_addr_reg + ADDR_W'(1);
                    if (int'(clr_addr_reg) == CELLS - 1) begin
                        state_reg <= clr_op_reg ? ST_FIN : ST_IDLE;
                    end
                end
                ST_IDLE: begin
                    if (accept) begin
                        op_reg  <= s_data.op;
                        res_reg <= '0;
                        xl_reg <= sx[0]; yl_reg <= sy[0]; zl_reg <= sz[0];
                        xm_reg <= sx[1]; ym_reg <= sy[1]; zm_reg <= sz[1];
                        xh_reg <= sx[2]; yh_reg <= sy[2]; zh_reg <= sz[2];
                        row_reg   <= sy[1];
                        upper_reg <= 1'b1;
                        case (s_data.op)
                            OP_DRAW: state_reg <= ST_ROW;
                            OP_READ: state_reg <= probe_in ? ST_RD : ST_FIN;
                            OP_CLEAR: begin
                                clr_addr_reg <= '0;
                                clr_op_reg   <= 1'b1;
                                state_reg    <= ST_CLR;
                            end
                            default: state_reg <= ST_FIN;
                        endcase
                    end
                end
                ST_RD: begin
                    res_reg   <= rd_ext[15:0];
                    state_reg <= ST_FIN;
                end
                ST_ROW: begin
                    k_reg <= 2'd0;
                    if (upper_reg && !(row_reg < yh_reg)) begin
                        upper_reg <= 1'b0;
                        row_reg   <= ym_reg;
                    end else if (!upper_reg && !(row_reg > yl_reg)) begin
                        state_reg <= ST_FIN;
                    end else if (int'(row_reg) < GRID_SIDE) begin
                        state_reg <= ST_EDGE;
                    end else begin
                        row_reg <= row_step;
                    end
                end
                ST_EDGE: begin
                    eneg_reg  <= e_diff[16];
                    ebase_reg <= e_v0;
                    state_reg <= ST_EDGE_W;
                end
                ST_EDGE_W: begin
                    if (div_done) begin
                        case (k_reg)
                            2'd0:    xa_reg <= e_val;
                            2'd1:    za_reg <= e_val;
                            2'd2:    xb_reg <= e_val;
                            default: zb_reg <= e_val;
                        endcase
                        k_reg     <= k_reg + 2'd1;
                        state_reg <= (k_reg == 2'd3) ? ST_SPAN : ST_EDGE;
                    end
                end
                ST_SPAN: begin
                    xr_reg    <= ref_a ? xa_reg[14:0] : xb_reg[14:0];
                    hi_reg    <= (xa_reg > xb_reg) ? xa_reg[14:0] : xb_reg[14:0];
                    i_reg     <= 7'((xa_reg > xb_reg) ? xb_reg[14:8] : xa_reg[14:8]);
                    zr_reg    <= ref_a ? za_reg : zb_reg;
                    dneg_reg  <= sp_d[26];
                    dmag_reg  <= sp_d[26] ? 24'(-sp_d) : sp_d[23:0];
                    dab_reg   <= div_divisor;
                    have_reg  <= 1'b0;
                    q_reg     <= '0;
                    rem_reg   <= '0;
                    state_reg <= (sp_x != 17'sd0) ? ST_QA_W : ST_PIX_T;
                end
                ST_QA_W: begin
                    if (div_done) begin
                        qa_reg    <= div_num_reg[31:0];
                        ra_reg    <= div_rem_reg;
                        state_reg <= ST_PIX_T;
                    end
                end
                ST_PIX_T: begin
                    if (!pix_go) begin
                        row_reg   <= row_step;
                        state_reg <= ST_ROW;
                    end else begin
                        have_reg  <= 1'b1;
                        tprev_reg <= t_cur;
                        if (div_start) begin
                            state_reg <= ST_PIX_DW;
                        end else begin
                            state_reg <= ST_PIX_W;
                            if (dab_reg == '0) begin
                                q_reg <= '0;
                            end else if ({1'b0, t_cur} == {1'b0, tprev_reg} + 15'd256) begin
                                if (inc_sum >= {1'b0, dab_reg}) begin
                                    rem_reg <= 14'(inc_sum - {1'b0, dab_reg});
                                    q_reg   <= q_reg + 38'(qa_reg) + 38'd1;
                                end else begin
                                    rem_reg <= inc_sum[13:0];
                                    q_reg   <= q_reg + 38'(qa_reg);
                                end
                            end else begin
                                if (rem_reg < ra_reg) begin
                                    rem_reg <= rem_reg + dab_reg - ra_reg;
                                    q_reg   <= q_reg - 38'(qa_reg) - 38'd1;
                                end else begin
                                    rem_reg <= rem_reg - ra_reg;
                                    q_reg   <= q_reg - 38'(qa_reg);
                                end
                            end
                        end
                    end
                end
                ST_PIX_DW: begin
                    if (div_done) begin
                        q_reg     <= div_num_reg;
                        rem_reg   <= div_rem_reg;
                        state_reg <= ST_PIX_W;
                    end
                end
                ST_PIX_W: begin
                    i_reg     <= i_reg + 7'd1;
                    state_reg <= ST_PIX_T;
                end
                ST_FIN: begin
                    if (!m_valid_reg || m_ready) begin
                        m_valid_reg            <= 1'b1;
                        m_data_reg.pixel_value <= res_reg;
                        m_data_reg.op_done     <= op_reg;
                        clr_op_reg             <= 1'b0;
                        state_reg              <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    `TSCD_ASSERT_CLK(a_div_idle_start, div_start |-> div_done, "Divider restarted while busy.")
    `TSCD_ASSERT_CLK(a_wr_in_grid, ram_we |-> (int'(ram_addr) < CELLS), "Write outside grid.")
    `TSCD_ASSERT_CLK(a_accept_leaves_idle, accept |=> (state_reg != ST_IDLE), "Transfer lost.")
    `TSCD_ASSERT_CLK(a_rem_below_den,
        ((state_reg == ST_PIX_W) && (dab_reg != '0)) |-> (rem_reg < dab_reg),
        "Span remainder not reduced.")

endmodule
`default_nettype wire

// ===== tb/sv/triangle_scan_convert_depth_checker.sv =====
// Checker that watches both channels, predicts each result of the rasteriser and compares it.
`timescale 1ns / 1ps
module triangle_scan_convert_depth_checker
    import tscd_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    input  logic      s_ready,
    input  tscd_in_t  s_data,
    input  logic      m_valid,
    input  logic      m_ready,
    input  tscd_out_t m_data,
    output int        fail_count,
    output int        pending_count
);
    localparam int SIDE = 32;
    localparam int ZMAX = 65535;

    logic [PIX_W-1:0] depth_grid [SIDE*SIDE];
    tscd_out_t        expected_results [$];

    function automatic longint edge_q8(longint v0, longint v1, longint num, longint den);
        return v0 * 256 + ((v1 - v0) * num * 256) / den;
    endfunction

    function automatic longint abs_l(longint a);
        return a < 0 ? -a : a;
    endfunction

    function automatic void fill_span(longint row, longint xr, longint zr, longint xo,
                                      longint zo);
        longint lo, hi, dab, z, pz;
        lo = xr < xo ? xr : xo;
        hi = xr < xo ? xo : xr;
        dab = abs_l(xo - xr);
        for (longint i = lo / 256; i * 256 < hi; i++) begin
            z = zr;
            if (dab != 0)
                z = zr + ((zo - zr) * abs_l(i * 256 - xr)) / dab;
            if (z < 0)
                pz = 0;
            else begin
                pz = z >>> 8;
                if (pz > ZMAX)
                    pz = ZMAX;
            end
            if (i >= 0 && i < SIDE && row >= 0 && row < SIDE)
                depth_grid[row * SIDE + i] = pz[PIX_W-1:0];
        end
    endfunction

    function automatic void draw_triangle(tscd_in_t t);
        longint x[3], y[3], z[3], tmp, xa, za, xb, zb;
        int pairs[3][2];
        x[0] = t.vertex0_x; y[0] = t.vertex0_y; z[0] = t.vertex0_z;
        x[1] = t.vertex1_x; y[1] = t.vertex1_y; z[1] = t.vertex1_z;
        x[2] = t.vertex2_x; y[2] = t.vertex2_y; z[2] = t.vertex2_z;
        pairs = '{'{0, 1}, '{1, 2}, '{0, 1}};
        foreach (pairs[p]) begin
            if (y[pairs[p][0]] > y[pairs[p][1]]) begin
                tmp = x[pairs[p][0]]; x[pairs[p][0]] = x[pairs[p][1]]; x[pairs[p][1]] = tmp;
                tmp = y[pairs[p][0]]; y[pairs[p][0]] = y[pairs[p][1]]; y[pairs[p][1]] = tmp;
                tmp = z[pairs[p][0]]; z[pairs[p][0]] = z[pairs[p][1]]; z[pairs[p][1]] = tmp;
            end
        end
        for (longint r = y[1]; r < y[2]; r++) begin
            xa = edge_q8(x[2], x[0], y[2] - r, y[2] - y[0]);
            za = edge_q8(z[2], z[0], y[2] - r, y[2] - y[0]);
            xb = edge_q8(x[2], x[1], y[2] - r, y[2] - y[1]);
            zb = edge_q8(z[2], z[1], y[2] - r, y[2] - y[1]);
            fill_span(r, xa, za, xb, zb);
        end
        for (longint r = y[1]; r > y[0]; r--) begin
            xa = edge_q8(x[2], x[0], y[2] - r, y[2] - y[0]);
            za = edge_q8(z[2], z[0], y[2] - r, y[2] - y[0]);
            xb = edge_q8(x[0], x[1], r - y[0], y[1] - y[0]);
            zb = edge_q8(z[0], z[1], r - y[0], y[1] - y[0]);
            if (xa > xb)
                fill_span(r, xb, zb, xa, za);
            else
                fill_span(r, xa, za, xb, zb);
        end
    endfunction

    function automatic tscd_out_t apply_operation(tscd_in_t t);
        tscd_out_t res;
        res.pixel_value = '0;
        res.op_done = t.op;
        case (t.op)
            OP_DRAW: draw_triangle(t);
            OP_READ: res.pixel_value = depth_grid[t.probe_row * SIDE + t.probe_col];
            OP_CLEAR: foreach (depth_grid[k]) depth_grid[k] = '0;
            default: ;
        endcase
        return res;
    endfunction

    assign pending_count = expected_results.size();

    always @(posedge aclk) begin
        tscd_out_t want;
        int errs;
        errs = 0;
        if (!aresetn) begin
            foreach (depth_grid[k]) depth_grid[k] = '0;
            expected_results.delete();
            fail_count <= 0;
        end else begin
            if (s_valid && s_ready)
                expected_results.push_back(apply_operation(s_data));
            if (m_valid && m_ready) begin
                if (expected_results.size() == 0) begin
                    $error("unexpected transfer on result channel: %p", m_data);
                    errs = errs + 1;
                end else begin
                    want = expected_results.pop_front();
                    if (m_data.pixel_value !== want.pixel_value) begin
                        $error("pixel_value expected %0d actual %0d",
                               want.pixel_value, m_data.pixel_value);
                        errs = errs + 1;
                    end
                    if (m_data.op_done !== want.op_done) begin
                        $error("op_done expected %0d actual %0d",
                               want.op_done, m_data.op_done);
                        errs = errs + 1;
                    end
                end
            end
            if (errs != 0)
                fail_count <= fail_count + errs;
        end
    end
endmodule

// ===== tb/sv/triangle_scan_convert_depth_tb.sv =====
// Top of the testbench: stimulus for the triangle depth rasteriser and the final verdict.
`timescale 1ns / 1ps
module triangle_scan_convert_depth_tb;
    import tscd_pkg::*;

    localparam int STALL_LIMIT = 200000;

    logic      aclk;
    logic      aresetn;
    logic      s_valid;
    logic      s_ready;
    tscd_in_t  s_data;
    logic      m_valid;
    logic      m_ready = 1'b0;
    tscd_out_t m_data;
    int        fail_count;
    int        pending_count;
    int        send_idle_pct = 23;
    int        recv_idle_pct = 86;
    int        quiet_cycles = 0;

    triangle_scan_convert_depth DUT (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data)
    );

    triangle_scan_convert_depth_checker checker_inst (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .fail_count(fail_count), .pending_count(pending_count)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        m_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // Valid stays high from one transfer to the next unless the sender idles.
    task automatic send_item(tscd_in_t t);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data <= t;
        @(posedge aclk);
        while (!s_ready)
            @(posedge aclk);
    endtask

    function automatic tscd_in_t random_item();
        tscd_in_t t;
        int sel;
        t = {$urandom, $urandom, $urandom};
        sel = $urandom_range(99);
        t.op = sel < 40 ? OP_DRAW : sel < 85 ? OP_READ : sel < 92 ? OP_CLEAR : OP_NOP;
        if (t.op == OP_DRAW && $urandom_range(3) != 0) begin
            // Mostly small triangles inside the grid keep the draw time short.
            t.vertex0_x = COORD_W'($urandom_range(31));
            t.vertex0_y = COORD_W'($urandom_range(31));
            t.vertex1_x = COORD_W'(int'(t.vertex0_x) + int'($urandom_range(7)) - 3);
            t.vertex1_y = COORD_W'(int'(t.vertex0_y) + int'($urandom_range(7)) - 3);
            t.vertex2_x = COORD_W'(int'(t.vertex0_x) + int'($urandom_range(7)) - 3);
            t.vertex2_y = COORD_W'(int'(t.vertex0_y) + int'($urandom_range(7)) - 3);
        end
        return t;
    endfunction

    function automatic tscd_in_t make_draw(int x0, int y0, int z0, int x1, int y1, int z1,
                                           int x2, int y2, int z2);
        tscd_in_t t;
        t = '0;
        t.op = OP_DRAW;
        t.vertex0_x = COORD_W'(x0); t.vertex0_y = COORD_W'(y0); t.vertex0_z = VZ_W'(z0);
        t.vertex1_x = COORD_W'(x1); t.vertex1_y = COORD_W'(y1); t.vertex1_z = VZ_W'(z1);
        t.vertex2_x = COORD_W'(x2); t.vertex2_y = COORD_W'(y2); t.vertex2_z = VZ_W'(z2);
        return t;
    endfunction

    function automatic tscd_in_t make_op(logic [OP_W-1:0] code, int col, int row);
        tscd_in_t t;
        t = {$urandom, $urandom, $urandom};
        t.op = code;
        t.probe_col = PROBE_W'(col);
        t.probe_row = PROBE_W'(row);
        return t;
    endfunction

    initial begin
        tscd_in_t directed [$];
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_data = '0;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        directed.push_back(make_op(OP_READ, 0, 0));
        directed.push_back(make_draw(0, 0, 0, 31, 0, 65535, 0, 31, 65535));
        directed.push_back(make_op(OP_READ, 0, 0));
        directed.push_back(make_op(OP_READ, 5, 5));
        directed.push_back(make_op(OP_READ, 31, 31));
        directed.push_back(make_draw(0, 0, 65535, 63, 63, 0, 0, 63, 65535));
        directed.push_back(make_op(OP_READ, 31, 30));
        directed.push_back(make_draw(3, 9, 100, 20, 9, 200, 8, 9, 300));
        directed.push_back(make_draw(10, 4, 1000, 10, 20, 2000, 10, 12, 3000));
        directed.push_back(make_op(OP_READ, 10, 12));
        directed.push_back(make_draw(40, 40, 500, 63, 50, 600, 45, 63, 700));
        directed.push_back(make_draw(2, 20, 65535, 30, 21, 0, 5, 22, 65535));
        directed.push_back(make_op(OP_READ, 4, 21));
        directed.push_back(make_op(OP_NOP, 0, 0));
        directed.push_back(make_op(OP_CLEAR, 0, 0));
        directed.push_back(make_op(OP_READ, 0, 0));
        directed.push_back(make_op(OP_READ, 31, 0));
        foreach (directed[k])
            send_item(directed[k]);

        for (int n = 0; n < 523; n++) begin
            if (n == 180) begin
                send_idle_pct = 86;
                recv_idle_pct = 23;
                s_valid <= 1'b0;
                @(posedge aclk);
                while (pending_count != 0)
                    @(posedge aclk);
            end
            if (n == 360) begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            send_item(random_item());
        end

        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending_count != 0)
            @(posedge aclk);
        repeat (50) @(posedge aclk);
        if (fail_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end
endmodule

// ===== files.f =====
+incdir+rtl
rtl/tscd_pkg.sv
rtl/tscd_ram.sv
rtl/triangle_scan_convert_depth.sv
tb/sv/triangle_scan_convert_depth_checker.sv
tb/sv/triangle_scan_convert_depth_tb.sv
